// ----- hw/rtl/zcpd_pkg.sv -----
// shared constants and types for the zero crossing phase difference block
package zcpd_pkg;
   localparam int NUM_OSC_DEF    = 8;
   localparam int TIME_BITS_DEF  = 32;
   localparam int PHASE_BITS_DEF = 16;
   localparam int IDX_W   = 3;
   localparam int CNT_W   = 4;
   localparam int VEL_W   = 16;
   localparam int OUT_PH_W = 16;
   localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;

   // controller to datapath commands
   typedef struct packed {
      logic take_item;   // capture input word and apply crossing update
      logic chk_start;   // clear completeness scan
      logic chk_step;    // scan one order entry
      logic ph_load;     // load divider operands for order entry sel
      logic div_step;    // one restoring division step
      logic ph_store;    // write divider result
      logic out_load;    // load output register for pair sel
      logic clr_cross;   // end of tick
   } cmd_type;

   typedef struct packed {
      logic last;        // captured last_of_tick
      logic crossed;     // crossing seen this tick
      logic all_seen;    // order complete
   } sts_type;
endpackage

// ----- hw/rtl/zcpd_ctrl.sv -----
// controller state machine for the zero crossing phase difference block
module zcpd_ctrl
   import zcpd_pkg::*;
#(
   parameter int NUM_OSC    = NUM_OSC_DEF,
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       out_full,
   input  logic                       rsp_ready,
   input  logic [$clog2(NUM_OSC+1)-1:0] cnt,
   input  sts_type                    sts,
   output cmd_type                    cmd,
   output logic [$clog2(NUM_OSC)-1:0] sel
);
   localparam int SW = $clog2(NUM_OSC);
   localparam int CW = $clog2(NUM_OSC+1);
   localparam int BW = $clog2(PHASE_BITS+1);

   typedef enum logic [2:0] {S_IDLE, S_EVAL, S_CHECK, S_LOAD, S_DIV, S_EMIT, S_WAIT}
      state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [BW-1:0]  bit_ff, bit_in;

   assign sel       = pos_ff[SW-1:0];
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      bit_in   = bit_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!sts.last) begin
               state_in = S_IDLE;
            end else if (!sts.crossed) begin
               cmd.clr_cross = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.chk_start = 1'b1;
               pos_in        = '0;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.chk_step = 1'b1;
            if (pos_ff == cnt - CW'(1)) begin
               pos_in   = CW'(1);
               state_in = S_LOAD;
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end
         S_LOAD: begin
            if (!sts.all_seen) begin
               cmd.clr_cross = 1'b1;
               state_in      = S_IDLE;
            end else if (pos_ff == cnt) begin
               pos_in   = '0;
               state_in = S_EMIT;
            end else begin
               cmd.ph_load = 1'b1;
               bit_in      = '0;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            bit_in       = bit_ff + BW'(1);
            if (bit_ff == BW'(PHASE_BITS - 1)) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            cmd.ph_store = 1'b1;
            pos_in       = pos_ff + CW'(1);
            state_in     = S_LOAD;
         end
         S_EMIT: begin
            if (!out_full || rsp_ready) begin
               cmd.out_load = 1'b1;
               if (pos_ff == cnt - CW'(2)) begin
                  cmd.clr_cross = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  pos_in = pos_ff + CW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         bit_ff   <= bit_in;
      end
   end

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAIT |-> $past(state_ff) == S_DIV) else $error("bad div exit");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |-> state_ff == S_IDLE) else $error("item taken while busy");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_full || rsp_ready)) else $error("output overrun");
endmodule

// ----- hw/rtl/zcpd_dp.sv -----
// datapath: crossing state, recency order, divider and output register
module zcpd_dp
   import zcpd_pkg::*;
#(
   parameter int NUM_OSC    = NUM_OSC_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [CNT_W-1:0]             csr_active_count_ff,
   input  logic [IDX_W-1:0]             req_osc_index,
   input  logic signed [VEL_W-1:0]      req_velocity,
   input  logic [TIME_BITS-1:0]         req_sample_time,
   input  logic                         req_last_of_tick,
   input  cmd_type                      cmd,
   input  logic [$clog2(NUM_OSC)-1:0]   sel,
   input  logic                         rsp_ready,
   output logic [$clog2(NUM_OSC+1)-1:0] cnt,
   output sts_type                      sts,
   output logic                         out_full,
   output logic                         rsp_valid,
   output logic [IDX_W-1:0]             rsp_pair_index,
   output logic [OUT_PH_W-1:0]          rsp_phase_diff,
   output logic [IDX_W-1:0]             rsp_oldest_osc,
   output logic                         rsp_last_pair
);
   localparam int SW = $clog2(NUM_OSC);
   localparam int CW = $clog2(NUM_OSC+1);
   localparam int TW = TIME_BITS;
   localparam int PW = PHASE_BITS;

   logic [NUM_OSC-1:0]         nonneg_ff, nonneg_in;
   logic [TW-1:0]              latest_ff [NUM_OSC];
   logic [TW-1:0]              prev_ff   [NUM_OSC];
   logic [SW-1:0]              order_ff  [NUM_OSC];
   logic [PW-1:0]              phase_ff  [NUM_OSC];
   logic                       cross_ff;
   logic                       last_ff;
   logic [NUM_OSC-1:0]         seen_ff;
   logic [TW:0]                rem_ff, rem_in;
   logic [TW-1:0]              den_ff;
   logic [PW-1:0]              quo_ff, quo_in;
   logic                       sat_ff, zero_ff;
   logic                       full_ff;
   logic [IDX_W-1:0]           pair_ff, old_ff;
   logic [OUT_PH_W-1:0]        diff_ff;
   logic                       lastp_ff;

   // effective active count, clamped to 2..NUM_OSC
   always_comb begin
      if (csr_active_count_ff < CNT_W'(2))
         cnt = CW'(2);
      else if (32'(csr_active_count_ff) > NUM_OSC)
         cnt = CW'(NUM_OSC);
      else
         cnt = CW'(csr_active_count_ff);
   end

   logic          act, neg, hit;
   logic [SW-1:0] ix;
   assign ix  = SW'(req_osc_index);
   assign act = (32'(req_osc_index) < 32'(cnt));
   assign neg = req_velocity[VEL_W-1];
   assign hit = cmd.take_item && act && nonneg_ff[ix] && neg;

   always_comb begin
      nonneg_in = nonneg_ff;
      if (cmd.take_item && act) nonneg_in[ix] = !neg;
   end

   // divider operands for the selected order entry
   logic [SW-1:0] dsel, oldest;
   logic [TW-1:0] i1, i2;
   assign dsel   = order_ff[sel];
   assign oldest = order_ff[0];
   assign i1     = latest_ff[dsel] - prev_ff[dsel];
   assign i2     = latest_ff[oldest] - prev_ff[dsel];

   logic [TW:0] sh;
   assign sh = {rem_ff[TW-1:0], 1'b0};
   always_comb begin
      rem_in = sh;
      quo_in = {quo_ff[PW-2:0], 1'b0};
      if (sh >= {1'b0, den_ff}) begin
         rem_in = sh - {1'b0, den_ff};
         quo_in[0] = 1'b1;
      end
   end

   logic [PW-1:0] dres;
   assign dres = zero_ff ? '0 : (sat_ff ? '1 : quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         nonneg_ff <= '1;
         cross_ff  <= 1'b0;
         full_ff   <= 1'b0;
         for (int i = 0; i < NUM_OSC; i++) begin
            latest_ff[i] <= '0;
            prev_ff[i]   <= '0;
            order_ff[i]  <= SW'(i);
            phase_ff[i]  <= '0;
         end
      end else begin
         nonneg_ff <= nonneg_in;
         if (cmd.take_item) last_ff <= req_last_of_tick;
         if (hit) begin
            prev_ff[ix]   <= latest_ff[ix];
            latest_ff[ix] <= req_sample_time;
            for (int c = 1; c < NUM_OSC; c++)
               if (c < 32'(cnt)) order_ff[c-1] <= order_ff[c];
            order_ff[SW'(cnt - CW'(1))] <= ix;
            cross_ff <= 1'b1;
         end
         if (cmd.clr_cross) cross_ff <= 1'b0;
         if (cmd.chk_start) seen_ff <= '0;
         if (cmd.chk_step && 32'(order_ff[sel]) < 32'(cnt)) seen_ff[order_ff[sel]] <= 1'b1;
         if (cmd.ph_load) begin
            phase_ff[oldest] <= '0;
            rem_ff  <= {1'b0, i2};
            den_ff  <= i1;
            quo_ff  <= '0;
            zero_ff <= (i1 == '0);
            sat_ff  <= (i2 >= i1);
         end
         if (cmd.div_step) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end
         if (cmd.ph_store) phase_ff[dsel] <= dres;
         if (cmd.out_load) begin
            full_ff  <= 1'b1;
            pair_ff  <= IDX_W'(sel);
            diff_ff  <= OUT_PH_W'(phase_ff[SW'(sel + SW'(1))] - phase_ff[0]);
            old_ff   <= IDX_W'(oldest);
            lastp_ff <= (32'(sel) + 2 == 32'(cnt));
         end else if (rsp_ready) begin
            full_ff <= 1'b0;
         end
      end
   end

   logic all_seen;
   always_comb begin
      all_seen = 1'b1;
      for (int c = 0; c < NUM_OSC; c++)
         if (c < 32'(cnt) && !seen_ff[c]) all_seen = 1'b0;
   end

   assign sts.last     = last_ff;
   assign sts.crossed  = cross_ff;
   assign sts.all_seen = all_seen;
   assign out_full       = full_ff;
   assign rsp_valid      = full_ff;
   assign rsp_pair_index = pair_ff;
   assign rsp_phase_diff = diff_ff;
   assign rsp_oldest_osc = old_ff;
   assign rsp_last_pair  = lastp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      32'(cnt) >= 2 && 32'(cnt) <= NUM_OSC) else $error("count out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      full_ff && !rsp_ready |=> full_ff) else $error("result dropped");
   a_cross_set: assert property (@(posedge clock) disable iff (reset)
      hit |=> cross_ff) else $error("crossing lost");
endmodule

// ----- hw/rtl/zero_crossing_phase_difference_top.sv -----
// top level of the zero crossing phase difference block
// an input word that ends no update is accepted in idle and then evaluated
// an update adds an order check over the active count, then load, restoring division
// steps and store per non-oldest oscillator on the shared divider, a closing step and
// one result word per pair, none if the order is incomplete; one word in work at a time
// synchronous active-high reset restores count 8, order 0..7 and clears times
module zero_crossing_phase_difference_top
   import zcpd_pkg::*;
#(
   parameter int NUM_OSC    = NUM_OSC_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CNT_W-1:0]        csr_write_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [IDX_W-1:0]        req_osc_index,
   input  logic signed [VEL_W-1:0] req_velocity,
   input  logic [TIME_BITS-1:0]    req_sample_time,
   input  logic                    req_last_of_tick,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_pair_index,
   output logic [OUT_PH_W-1:0]     rsp_phase_diff,
   output logic [IDX_W-1:0]        rsp_oldest_osc,
   output logic                    rsp_last_pair
);
   // active count register
   logic [CNT_W-1:0] count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   cmd_type                      cmd;
   sts_type                      sts;
   logic [$clog2(NUM_OSC)-1:0]   sel;
   logic [$clog2(NUM_OSC+1)-1:0] cnt;
   logic                         out_full;

   // sequencer
   zcpd_ctrl #(.NUM_OSC(NUM_OSC), .PHASE_BITS(PHASE_BITS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .out_full, .rsp_ready,
      .cnt, .sts, .cmd, .sel
   );

   // state, divider and output word register
   zcpd_dp #(.NUM_OSC(NUM_OSC), .TIME_BITS(TIME_BITS), .PHASE_BITS(PHASE_BITS)) u_dp (
      .clock, .reset, .csr_active_count_ff(count_ff),
      .req_osc_index, .req_velocity, .req_sample_time, .req_last_of_tick,
      .cmd, .sel, .rsp_ready, .cnt, .sts, .out_full,
      .rsp_valid, .rsp_pair_index, .rsp_phase_diff, .rsp_oldest_osc, .rsp_last_pair
   );
endmodule
